// ===== src/pidaw_pkg.sv =====
// Shared types and constants for the PID controller with anti-windup.
// Holds the sequencer state type, register indexes and datapath widths.
// No dependencies.
`default_nettype none

package pidaw_pkg;

    // Sequencer states: idle, then one multiplier issue or one add, select or clamp step each
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_FNEW,
        S_MUL_FOLD,
        S_DERIV,
        S_MUL_D,
        S_POT,
        S_SELECT,
        S_MUL_I,
        S_INTEG,
        S_SUM
    } t_state;

    // Configuration register indexes
    localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
    localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
    localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd3;
    localparam logic [2:0] REG_DRIVE_LIMIT = 3'd4;
    localparam logic [2:0] REG_INTEG_LIMIT = 3'd5;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Derivative filter weights in 1/256 units
    localparam logic signed [MUL_A_W-1:0] DERIV_NEW_WEIGHT = 17'sd205;
    localparam logic signed [MUL_A_W-1:0] DERIV_OLD_WEIGHT = 17'sd51;

endpackage

`default_nettype wire

// ===== src/pidaw_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on pidaw_pkg for operand widths.
`default_nettype none

module pidaw_mul (
    input  wire                                    i_clk,
    input  wire logic signed [pidaw_pkg::MUL_A_W-1:0] i_a,
    input  wire logic signed [pidaw_pkg::MUL_B_W-1:0] i_b,
    output logic signed [pidaw_pkg::MUL_P_W-1:0]      o_p
);
    import pidaw_pkg::*;

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== src/pid_antiwindup_controller.sv =====
// PID controller: deadband, filtered derivative, back-calculation anti-windup.
// Each word passes through ten sequencer steps around the shared multiplier after the idle
// state that takes it; a new word is taken only once the last is done, and a stalled drive
// word holds the last step.
// Reset (synchronous, active low) loads default registers and zeroes the controller state.
// Depends on pidaw_pkg and pidaw_mul.
`default_nettype none

module pid_antiwindup_controller (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [15:0] i_cfg_wdata,
    // Error stream in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] error_in
    // Drive stream out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] drive
);
    import pidaw_pkg::*;

    // Configuration registers
    logic [15:0] r_gain_prop;
    logic [15:0] r_gain_integ;
    logic [15:0] r_gain_deriv;
    logic [14:0] r_dead_band;
    logic [14:0] r_drive_limit;
    logic [14:0] r_integ_limit;

    // Controller state
    logic signed [15:0] r_prev_error;
    logic signed [19:0] r_filt_deriv;
    logic signed [31:0] r_integ_accum;

    // Per-item working registers
    t_state             r_state, n_state;
    logic signed [15:0] r_err;
    logic signed [29:0] r_p;
    logic signed [29:0] r_d;
    logic signed [27:0] r_fnew;
    logic signed [30:0] r_pot;
    logic signed [31:0] r_opnd;
    logic               r_inside;
    logic               r_out_valid;
    logic [15:0]        r_drive;

    // Shared multiplier
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [MUL_P_W-1:0] w_prod_sh4;
    logic signed [MUL_P_W-1:0] w_prod_sh8;

    logic signed [16:0] w_in_mag;
    logic signed [16:0] w_diff;
    logic signed [28:0] w_fsum;
    logic signed [30:0] w_pot_abs;
    logic signed [30:0] w_lim31;
    logic signed [31:0] w_excess;
    logic signed [49:0] w_integ_sum;
    logic signed [49:0] w_ilim;
    logic signed [31:0] w_integ_clamped;
    logic signed [32:0] w_out_sum;
    logic signed [32:0] w_olim;
    logic signed [32:0] w_out_clamped;
    logic               w_load_out;

    pidaw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    assign w_prod_sh4 = w_prod >>> 4;
    assign w_prod_sh8 = w_prod >>> 8;

    // Deadband test on the raw input word
    assign w_in_mag = s_axis_tdata[15] ? -{s_axis_tdata[15], s_axis_tdata}
                                       :  {1'b0, s_axis_tdata};

    // Error difference for the derivative filter
    assign w_diff = {r_err[15], r_err} - {r_prev_error[15], r_prev_error};

    // Filter: (205*diff + 51*old) floored by 256
    assign w_fsum = {r_fnew[27], r_fnew} + {w_prod[27], w_prod[27:0]};

    // Potential output against the drive limit (limit scaled to Q23.8)
    assign w_lim31   = {8'b0, r_drive_limit, 8'b0};
    assign w_pot_abs = r_pot[30] ? -r_pot : r_pot;
    assign w_excess  = (r_pot > 31'sd0) ? ({1'b0, w_lim31} - {r_pot[30], r_pot})
                                        : (-{1'b0, w_lim31} - {r_pot[30], r_pot});

    // Integral update at full width, then clamp
    assign w_ilim = {27'b0, r_integ_limit, 8'b0};
    assign w_integ_sum = {{18{r_integ_accum[31]}}, r_integ_accum}
                       + (r_inside ? {w_prod_sh4[48], w_prod_sh4}
                                   : {w_prod_sh8[48], w_prod_sh8});

    always_comb begin
        if (w_integ_sum > w_ilim) begin
            w_integ_clamped = w_ilim[31:0];
        end else if (w_integ_sum < -w_ilim) begin
            w_integ_clamped = 32'(-w_ilim);
        end else begin
            w_integ_clamped = w_integ_sum[31:0];
        end
    end

    // Output: P + I + D saturated to the drive limit
    assign w_olim    = {10'b0, r_drive_limit, 8'b0};
    assign w_out_sum = {{3{r_p[29]}}, r_p} + {{3{r_d[29]}}, r_d}
                     + {r_integ_accum[31], r_integ_accum};

    always_comb begin
        if (w_out_sum > w_olim) begin
            w_out_clamped = w_olim;
        end else if (w_out_sum < -w_olim) begin
            w_out_clamped = -w_olim;
        end else begin
            w_out_clamped = w_out_sum;
        end
    end

    // Hold the sum step until the output register is free
    assign w_load_out = !r_out_valid || m_axis_tready;

    // Multiplier operand select and next state
    always_comb begin
        n_state = r_state;
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_MUL_P;
                end
            end
            S_MUL_P: begin
                w_mul_a = {1'b0, r_gain_prop};
                w_mul_b = {{16{r_err[15]}}, r_err};
                n_state = S_MUL_FNEW;
            end
            S_MUL_FNEW: begin
                w_mul_a = DERIV_NEW_WEIGHT;
                w_mul_b = {{15{w_diff[16]}}, w_diff};
                n_state = S_MUL_FOLD;
            end
            S_MUL_FOLD: begin
                w_mul_a = DERIV_OLD_WEIGHT;
                w_mul_b = {{12{r_filt_deriv[19]}}, r_filt_deriv};
                n_state = S_DERIV;
            end
            S_DERIV: begin
                n_state = S_MUL_D;
            end
            S_MUL_D: begin
                w_mul_a = {1'b0, r_gain_deriv};
                w_mul_b = {{12{r_filt_deriv[19]}}, r_filt_deriv};
                n_state = S_POT;
            end
            S_POT: begin
                n_state = S_SELECT;
            end
            S_SELECT: begin
                n_state = S_MUL_I;
            end
            S_MUL_I: begin
                w_mul_a = {1'b0, r_gain_integ};
                w_mul_b = r_opnd;
                n_state = S_INTEG;
            end
            S_INTEG: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes; drop unknown indexes and excess bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop   <= 16'd256;
            r_gain_integ  <= 16'd0;
            r_gain_deriv  <= 16'd0;
            r_dead_band   <= 15'd82;
            r_drive_limit <= 15'd24320;
            r_integ_limit <= 15'd20480;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GAIN_PROP:   r_gain_prop   <= i_cfg_wdata;
                REG_GAIN_INTEG:  r_gain_integ  <= i_cfg_wdata;
                REG_GAIN_DERIV:  r_gain_deriv  <= i_cfg_wdata;
                REG_DEAD_BAND:   r_dead_band   <= i_cfg_wdata[14:0];
                REG_DRIVE_LIMIT: r_drive_limit <= i_cfg_wdata[14:0];
                REG_INTEG_LIMIT: r_integ_limit <= i_cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state: filter in S_DERIV, integral in S_INTEG, last error at item end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_error  <= '0;
            r_filt_deriv  <= '0;
            r_integ_accum <= '0;
        end else begin
            if (r_state == S_DERIV) begin
                r_filt_deriv <= w_fsum[27:8];
            end
            if (r_state == S_INTEG) begin
                r_integ_accum <= w_integ_clamped;
            end
            if (r_state == S_SUM && w_load_out) begin
                r_prev_error <= r_err;
            end
        end
    end

    // Working registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && s_axis_tvalid) begin
            // Zero errors inside the deadband
            r_err <= (w_in_mag < {2'b0, r_dead_band}) ? 16'sd0 : s_axis_tdata;
        end
        if (r_state == S_MUL_FNEW) begin
            r_p <= w_prod_sh4[29:0];
        end
        if (r_state == S_MUL_FOLD) begin
            r_fnew <= w_prod[27:0];
        end
        if (r_state == S_POT) begin
            r_d   <= w_prod_sh4[29:0];
            r_pot <= {r_p[29], r_p} + {w_prod_sh4[29], w_prod_sh4[29:0]};
        end
        if (r_state == S_SELECT) begin
            // Integrate the error inside the limit, else the back-calculated excess
            r_inside <= (w_pot_abs < w_lim31);
            r_opnd   <= (w_pot_abs < w_lim31) ? {{16{r_err[15]}}, r_err} : w_excess;
        end
        if (r_state == S_SUM && w_load_out) begin
            r_drive <= w_out_clamped[23:8];
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_SUM && w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_drive;

endmodule

`default_nettype wire
